@@ sv/idl_pkg.sv @@
// Shared types, constants and opcodes for the identifier list core.
`default_nettype none

package idl_pkg;

	// Field widths
	localparam int PID_W     = 23;
	localparam int TYPE_W    = 2;
	localparam int LIMIT_W   = 7;
	localparam int FIDX_W    = 6;
	localparam int OUT_CNT_W = 7;

	// Stream word widths (fields packed from bit 0, padded to bytes)
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// Defaults
	localparam int                 LIST_DEPTH_DEF = 64;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 7'd64;

	// Request opcodes
	localparam logic [TYPE_W-1:0] OP_ADD    = 2'd0;
	localparam logic [TYPE_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [TYPE_W-1:0] OP_FIND   = 2'd2;

	// Result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY
	} state_t;

	// Per-request update strobes broadcast to every cell
	typedef struct packed {
		logic add_en;
		logic rm_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/idl_cell.sv @@
// One list cell: holds an identifier, compares it and shifts from its upper neighbor.
`default_nettype none

module idl_cell
	import idl_pkg::*;
#(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 7,
	parameter int IDX_W    = 6
) (
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [CNT_W-1:0] count,
	input  wire logic [IDX_W-1:0] hit_idx,
	input  wire logic [PID_W-1:0] pid,
	input  wire logic [PID_W-1:0] next_entry,
	output logic      [PID_W-1:0] entry,
	output logic                  match
);

	logic [PID_W-1:0] entry_q;
	logic             live;
	logic             wr_here;
	logic             shift_here;

	// Decode what this position does for the current request
	always_comb begin
		live       = CNT_W'(CELL_IDX) < count;
		wr_here    = ctrl.add_en && (count == CNT_W'(CELL_IDX));
		shift_here = ctrl.rm_en && (IDX_W'(CELL_IDX) >= hit_idx)
			&& (CNT_W'(CELL_IDX + 1) < count);
		match      = live && (entry_q == pid);
	end

	// Load on append, take the neighbor's word on a closing shift
	always_ff @(posedge clk) begin
		if (wr_here) begin
			entry_q <= pid;
		end else if (shift_here) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

@@ sv/idl_first_hit.sv @@
// Registered binary tree that finds the lowest matching cell position.
`default_nettype none

module idl_first_hit
	import idl_pkg::*;
#(
	parameter int DEPTH = LIST_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic [DEPTH-1:0]         match,
	output logic                          hit,
	output logic [$clog2(DEPTH)-1:0]      hit_idx
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int LEAVES = 1 << IDX_W;
	localparam int NODES  = 2 * LEAVES - 1;

	// Heap layout: node n has children 2n+1 and 2n+2, leaves start at LEAVES-1
	logic             hit_q [NODES];
	logic [IDX_W-1:0] idx_q [NODES];

	// Advance every level each cycle; the lower child wins on a tie
	always_ff @(posedge clk) begin
		for (int j = 0; j < LEAVES; j++) begin
			hit_q[LEAVES-1+j] <= (j < DEPTH) ? match[j] : 1'b0;
			idx_q[LEAVES-1+j] <= IDX_W'(j);
		end
		for (int n = 0; n < LEAVES - 1; n++) begin
			hit_q[n] <= hit_q[2*n+1] | hit_q[2*n+2];
			idx_q[n] <= hit_q[2*n+1] ? idx_q[2*n+1] : idx_q[2*n+2];
		end
	end

	assign hit     = hit_q[0];
	assign hit_idx = idx_q[0];

endmodule

`default_nettype wire

@@ sv/id_list_add_remove_find_core.sv @@
// Top level of the bounded identifier list with add, remove and find.
//
//  channel | direction | handshake          | word contents (lowest bit first)
//  s_*     | in        | s_tvalid/s_tready  | tdata: pid_value[22:0]; tuser: req_type[1:0]
//  m_*     | out       | m_tvalid/m_tready  | tdata: found_index[5:0], entry_count[12:6];
//          |           |                    | tuser: status[0]
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_data: list_limit[6:0]
//
// One request is in work at a time; it passes through a search state and
// then apply, the search spanning the registered first-match tree that follows
// the parallel compare in the cell row.
// A new request is taken while the previous result still waits in the
// output register; a stalled output holds the finished request in apply.
// Reset clears the count and sets list_limit to 64; cell contents are
// undefined until written and are never read above the count.
`default_nettype none

module id_list_add_remove_find_core
	import idl_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// pid_value[22:0], zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  wire logic [TYPE_W-1:0]    s_tuser,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// found_index[5:0], entry_count[12:6], zero pad
	output logic [M_TDATA_W-1:0]      m_tdata,
	// status[0]
	output logic [0:0]                m_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [LIMIT_W-1:0]   cfg_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready
);

	localparam int IDX_W   = $clog2(LIST_DEPTH);
	localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int SRCH_N  = IDX_W + 1;
	localparam int SCNT_W  = $clog2(SRCH_N + 1);

	state_t              state_q, state_d;
	logic [SCNT_W-1:0]   srch_cnt_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [CNT_W-1:0]    count_q;
	logic [TYPE_W-1:0]   op_q;
	logic [PID_W-1:0]    pid_q;

	logic                out_valid_q;
	logic                out_status_q;
	logic [FIDX_W-1:0]   out_idx_q;
	logic [OUT_CNT_W-1:0] out_cnt_q;

	logic                in_fire;
	logic                out_free;
	logic                apply_fire;
	logic                search_last;

	logic [PID_W-1:0]    entries [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] match_vec;
	logic                root_hit;
	logic [IDX_W-1:0]    root_idx;
	cell_ctrl_t          cell_ctrl;

	logic                can_add;
	logic                res_status;
	logic [CNT_W-1:0]    res_count;
	logic [IDX_W+FIDX_W-1:0]       idx_wide;
	logic [CNT_W+OUT_CNT_W-1:0]    cnt_wide;

	// Configuration register is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// Handshake strobes
	assign in_fire     = s_tvalid && s_tready;
	assign out_free    = !out_valid_q || m_tready;
	assign search_last = srch_cnt_q == SCNT_W'(SRCH_N - 1);

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_SEARCH;
			ST_SEARCH: if (search_last) state_d = ST_APPLY;
			ST_APPLY:  if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready   = 1'b0;
		apply_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SEARCH: ;
			ST_APPLY:  apply_fire = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			srch_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				srch_cnt_q <= '0;
			end else if (state_q == ST_SEARCH) begin
				srch_cnt_q <= srch_cnt_q + SCNT_W'(1);
			end
		end
	end

	// Capture the request word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= s_tuser;
			pid_q <= s_tdata[PID_W-1:0];
		end
	end

	// Cell row
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic [PID_W-1:0] nbr;
		assign nbr = (i == LIST_DEPTH - 1) ? entries[i] : entries[(i + 1) % LIST_DEPTH];
		idl_cell #(
			.CELL_IDX (i),
			.CNT_W    (CNT_W),
			.IDX_W    (IDX_W)
		) u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.count      (count_q),
			.hit_idx    (root_idx),
			.pid        (pid_q),
			.next_entry (nbr),
			.entry      (entries[i]),
			.match      (match_vec[i])
		);
	end

	idl_first_hit #(
		.DEPTH (LIST_DEPTH)
	) u_first_hit (
		.clk     (clk),
		.match   (match_vec),
		.hit     (root_hit),
		.hit_idx (root_idx)
	);

	// Form the result and the cell strobes
	always_comb begin
		can_add = (CMP_W'(count_q) < CMP_W'(limit_q))
			&& (CMP_W'(count_q) < CMP_W'(LIST_DEPTH));
		cell_ctrl.add_en = 1'b0;
		cell_ctrl.rm_en  = 1'b0;
		res_status = STATUS_FAIL;
		res_count  = count_q;
		idx_wide   = '0;
		unique case (op_q)
			OP_ADD: begin
				if (can_add) begin
					cell_ctrl.add_en = apply_fire;
					res_status       = STATUS_OK;
					res_count        = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (root_hit) begin
					cell_ctrl.rm_en = apply_fire;
					res_status      = STATUS_OK;
					res_count       = count_q - CNT_W'(1);
					idx_wide        = {{FIDX_W{1'b0}}, root_idx};
				end
			end
			OP_FIND: begin
				if (root_hit) begin
					res_status = STATUS_OK;
					idx_wide   = {{FIDX_W{1'b0}}, root_idx};
				end
			end
			default: ;
		endcase
		cnt_wide = {{OUT_CNT_W{1'b0}}, res_count};
	end

	// Commit the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply_fire) begin
			count_q <= res_count;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			out_status_q <= res_status;
			out_idx_q    <= idx_wide[FIDX_W-1:0];
			out_cnt_q    <= cnt_wide[OUT_CNT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(M_TDATA_W - FIDX_W - OUT_CNT_W){1'b0}}, out_cnt_q, out_idx_q};

endmodule

`default_nettype wire

@@ sv/idl_checker.sv @@
// Port-level checks on the identifier list core, bound to the top level.
`default_nettype none

module idl_checker
	import idl_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [0:0]           m_tuser,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed under stall");

	// Only one request in work: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	// A failed request reports index zero
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == STATUS_FAIL) |-> m_tdata[FIDX_W-1:0] == '0)
		else $error("failed request carries a nonzero index");

	// A result never appears straight after the request that caused it when no older result waits
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
		else $error("result appeared too early");

endmodule

bind id_list_add_remove_find_core idl_checker u_idl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

`default_nettype wire

@@ verif/id_list_checker.sv @@
// Checker for the identifier list core: tracks the list, predicts each reply and compares.
module id_list_checker
	import idl_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// pid_value[22:0], zero pad
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  wire logic [TYPE_W-1:0]    s_tuser,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	// found_index[5:0], entry_count[12:6], zero pad
	input  wire logic [M_TDATA_W-1:0] m_tdata,
	// status[0]
	input  wire logic [0:0]           m_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [LIMIT_W-1:0]   cfg_data,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	output int                        fail_count,
	output int                        pending
);

	typedef struct packed {
		logic                 status;
		logic [FIDX_W-1:0]    index;
		logic [OUT_CNT_W-1:0] count;
	} list_reply_t;

	list_reply_t          expected_replies[$];
	logic [PID_W-1:0]     shadow_ids [LIST_DEPTH];
	int                   shadow_count;
	logic [LIMIT_W-1:0]   shadow_limit;

	// Apply one request to the shadow list and return the reply it should give
	function automatic list_reply_t predict_reply(input logic [TYPE_W-1:0] op,
			input logic [PID_W-1:0] pid);
		list_reply_t r;
		int          hit;
		int          room;
		r.status = STATUS_FAIL;
		r.index  = '0;
		room = (int'(shadow_limit) < LIST_DEPTH) ? int'(shadow_limit) : LIST_DEPTH;
		hit = -1;
		for (int i = 0; i < shadow_count; i++)
			if (hit < 0 && shadow_ids[i] == pid)
				hit = i;
		case (op)
			OP_ADD: begin
				if (shadow_count < room) begin
					shadow_ids[shadow_count] = pid;
					shadow_count++;
					r.status = STATUS_OK;
				end
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					shadow_count--;
					for (int i = hit; i < shadow_count; i++)
						shadow_ids[i] = shadow_ids[i + 1];
					r.status = STATUS_OK;
					r.index  = FIDX_W'(hit);
				end
			end
			OP_FIND: begin
				if (hit >= 0) begin
					r.status = STATUS_OK;
					r.index  = FIDX_W'(hit);
				end
			end
			default: ;
		endcase
		r.count = OUT_CNT_W'(shadow_count);
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Retire reply words, follow limit writes, predict accepted requests
	always @(posedge clk or negedge arst_n) begin
		list_reply_t want;
		if (!arst_n) begin
			shadow_count = 0;
			shadow_limit = LIMIT_RESET;
			expected_replies.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: reply word with nothing expected, actual status %0d index %0d count %0d",
						$time, m_tuser[0], m_tdata[FIDX_W-1:0],
						m_tdata[FIDX_W +: OUT_CNT_W]);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					check_field("status", want.status, m_tuser[0]);
					check_field("found_index", want.index, m_tdata[FIDX_W-1:0]);
					check_field("entry_count", want.count, m_tdata[FIDX_W +: OUT_CNT_W]);
				end
			end
			if (cfg_valid && cfg_ready)
				shadow_limit = cfg_data;
			if (s_tvalid && s_tready)
				expected_replies.push_back(predict_reply(s_tuser, s_tdata[PID_W-1:0]));
			pending <= expected_replies.size();
		end
	end

endmodule

@@ verif/id_list_add_remove_find_core_test.sv @@
// Testbench top for the identifier list core: stimulus, flow control and verdict.
module id_list_add_remove_find_core_test;
	import idl_pkg::*;

	localparam logic [TYPE_W-1:0] OP_UNKNOWN  = 2'd3;
	localparam int                DRAIN_WAIT  = 20;
	localparam int                LONG_HOLD   = 150;
	localparam int                PHASE_ITEMS = 210;

	logic                  clk;
	logic                  arst_n;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [TYPE_W-1:0]     s_tuser;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [LIMIT_W-1:0]    cfg_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	int                    fail_count;
	int                    pending;

	// calm and hold_req are shared between the sender and the receiver process; pid_pool feeds the sender
	bit                    calm;
	bit                    hold_req;
	logic [PID_W-1:0]      pid_pool [8];

	id_list_add_remove_find_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_data  (cfg_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready)
	);

	id_list_checker list_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cfg_data   (cfg_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short idle stretches, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one request word and hold it until the core takes it
	task automatic send_request(input logic [TYPE_W-1:0] op, input logic [PID_W-1:0] pid);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tuser  <= op;
		s_tdata  <= {{(S_TDATA_W - PID_W){1'b0}}, pid};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid, let the list go idle, then write list_limit
	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [PID_W-1:0] pick_pid();
		if ($urandom_range(0, 99) < 85)
			return pid_pool[$urandom_range(0, 7)];
		return PID_W'($urandom);
	endfunction

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	// Stop a hung run
	initial begin
		#10000000;
		$display("FAIL id_list_add_remove_find_core");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		logic [LIMIT_W-1:0] phase_limit [8];
		logic [TYPE_W-1:0]  op;
		int                 add_pct;
		int                 r;
		int                 waited;

		phase_limit = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd5, 7'd64, 7'd40, 7'd2};
		calm      = 1'b0;
		hold_req  = 1'b0;
		arst_n    <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_ADD;
		s_tvalid  <= 1'b0;
		cfg_data  <= LIMIT_RESET;
		cfg_valid <= 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty list, extreme identifiers, duplicates, shifts, unknown op
		send_request(OP_FIND, 23'h000001);
		send_request(OP_REMOVE, 23'h000000);
		send_request(OP_ADD, 23'h000000);
		send_request(OP_ADD, 23'h7FFFFF);
		send_request(OP_ADD, 23'h555555);
		send_request(OP_ADD, 23'h2AAAAA);
		send_request(OP_ADD, 23'h000000);
		send_request(OP_FIND, 23'h000000);
		send_request(OP_FIND, 23'h7FFFFF);
		send_request(OP_FIND, 23'h000123);
		send_request(OP_REMOVE, 23'h000000);
		send_request(OP_FIND, 23'h000000);
		send_request(OP_UNKNOWN, 23'h7FFFFF);
		send_request(OP_REMOVE, 23'h555555);
		// Limit below the count: adds fail, find and remove still work
		write_limit(7'd2);
		send_request(OP_ADD, 23'h000001);
		send_request(OP_FIND, 23'h2AAAAA);
		send_request(OP_REMOVE, 23'h000000);
		// Zero limit: every add fails
		write_limit(7'd0);
		send_request(OP_ADD, 23'h7FFFFF);
		send_request(OP_REMOVE, 23'h7FFFFF);

		// Random phases: fill-heavy first half, drain-heavy second half
		for (int p = 0; p < 8; p++) begin
			write_limit(phase_limit[p]);
			calm = (p == 2 || p == 5);
			for (int j = 0; j < 8; j++)
				pid_pool[j] = PID_W'($urandom);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 0 && k == 20)
					hold_req = 1'b1;
				add_pct = (k < PHASE_ITEMS / 2) ? 70 : 25;
				r = $urandom_range(0, 99);
				if (r < 3)
					op = OP_UNKNOWN;
				else if (r < 3 + add_pct)
					op = OP_ADD;
				else if (r < 3 + add_pct + (97 - add_pct) / 2)
					op = OP_REMOVE;
				else
					op = OP_FIND;
				send_request(op, pick_pid());
			end
		end
		calm = 1'b0;

		// Drain and give the verdict
		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
		if (pending != 0)
			$display("%0t: %0d replies expected but never delivered", $time, pending);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS id_list_add_remove_find_core");
		end else begin
			$display("FAIL id_list_add_remove_find_core");
		end
		$finish;
	end

endmodule

@@ id_list_add_remove_find_core.f @@
sv/idl_pkg.sv
sv/idl_cell.sv
sv/idl_first_hit.sv
sv/id_list_add_remove_find_core.sv
sv/idl_checker.sv
verif/id_list_checker.sv
verif/id_list_add_remove_find_core_test.sv
